>>> design/multi_granularity_lock_grant_core_macros.svh
// ----------------------------------------------------------------------------
// multi_granularity_lock_grant_core_macros.svh
// assertion macros shared by the lock grant checker
// ----------------------------------------------------------------------------
`ifndef MULTI_GRANULARITY_LOCK_GRANT_CORE_MACROS_SVH
`define MULTI_GRANULARITY_LOCK_GRANT_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MGLG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define MGLG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mglg_pkg.sv
// ----------------------------------------------------------------------------
// mglg_pkg
// modes, result kinds, compatibility table and controller/datapath link types
// ----------------------------------------------------------------------------
package mglg_pkg;

  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_IS   = 3'd1;
  localparam logic [2:0] MODE_IX   = 3'd2;
  localparam logic [2:0] MODE_S    = 3'd3;
  localparam logic [2:0] MODE_SIX  = 3'd4;
  localparam logic [2:0] MODE_X    = 3'd5;

  localparam logic [2:0] KIND_NOW        = 3'd0;
  localparam logic [2:0] KIND_QUEUED     = 3'd1;
  localparam logic [2:0] KIND_RELEASED   = 3'd2;
  localparam logic [2:0] KIND_FROM_QUEUE = 3'd3;
  localparam logic [2:0] KIND_NOT_HOLDER = 3'd4;
  localparam logic [2:0] KIND_FULL       = 3'd5;

  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // row per held mode, bit per requested mode
  localparam logic [5:0] COMPAT_ROWS [6] = '{
    6'b111111,
    6'b011111,
    6'b000111,
    6'b001011,
    6'b000011,
    6'b000001
  };

  function automatic logic [2:0] clip_mode(logic [2:0] m);
    return (m > MODE_X) ? MODE_X : m;
  endfunction

  function automatic logic compat(logic [2:0] held, logic [2:0] req);
    logic [5:0] row;
    row = COMPAT_ROWS[clip_mode(held)];
    return row[clip_mode(req)];
  endfunction

  typedef enum logic [1:0] {
    SRC_REQ     = 2'd0,
    SRC_NOTHOLD = 2'd1,
    SRC_REL     = 2'd2,
    SRC_PEND    = 2'd3
  } out_src_e;

  typedef struct packed {
    logic     latch;
    logic     idx_clr;
    logic     idx_inc;
    logic     hold_rd;
    logic     hold_rd_next;
    logic     hold_copy;
    logic     found;
    logic     hc_dec;
    logic     req_do;
    logic     wait_rd;
    logic     drain_grant;
    logic     pend_rel;
    logic     out_load;
    logic     out_last;
    out_src_e out_src;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic hc_zero;
    logic idx_at_hc;
    logic idx_last;
    logic match;
    logic wait_empty;
    logic hold_full;
    logic drain_ok;
    logic out_free;
  } st_t;

endpackage

>>> design/mglg_ctrl.sv
// ----------------------------------------------------------------------------
// mglg_ctrl
// sequencer for request, holder search/shift, release and queue drain
// ----------------------------------------------------------------------------
module mglg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mglg_pkg::st_t  st_i,
  output mglg_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_REQ    = 9'b000000010,
    ST_SR_RD  = 9'b000000100,
    ST_SR_CMP = 9'b000001000,
    ST_SH_RD  = 9'b000010000,
    ST_SH_WR  = 9'b000100000,
    ST_REL    = 9'b001000000,
    ST_DR_RD  = 9'b010000000,
    ST_DR_CHK = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch   = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_REQ;
        end
      end
      ST_REQ: begin
        // func is known only after latching
        if (st_i.func == mglg_pkg::FUNC_RELEASE) begin
          state_d = ST_SR_RD;
        end else if (st_i.out_free) begin
          cmd_o.req_do   = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.out_src  = mglg_pkg::SRC_REQ;
          state_d        = ST_IDLE;
        end
      end
      ST_SR_RD: begin
        if (st_i.idx_at_hc) begin
          if (st_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_last = 1'b1;
            cmd_o.out_src  = mglg_pkg::SRC_NOTHOLD;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.hold_rd = 1'b1;
          state_d       = ST_SR_CMP;
        end
      end
      ST_SR_CMP: begin
        if (st_i.match) begin
          cmd_o.found = 1'b1;
          state_d     = ST_SH_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_SR_RD;
        end
      end
      ST_SH_RD: begin
        if (st_i.idx_last) begin
          cmd_o.hc_dec = 1'b1;
          state_d      = ST_REL;
        end else begin
          cmd_o.hold_rd_next = 1'b1;
          state_d            = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd_o.hold_copy = 1'b1;
        cmd_o.idx_inc   = 1'b1;
        state_d         = ST_SH_RD;
      end
      ST_REL: begin
        if (!st_i.hc_zero || st_i.wait_empty) begin
          if (st_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_last = 1'b1;
            cmd_o.out_src  = mglg_pkg::SRC_REL;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.pend_rel = 1'b1;
          state_d        = ST_DR_RD;
        end
      end
      ST_DR_RD: begin
        if (st_i.wait_empty || st_i.hold_full) begin
          if (st_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_last = 1'b1;
            cmd_o.out_src  = mglg_pkg::SRC_PEND;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.wait_rd = 1'b1;
          state_d       = ST_DR_CHK;
        end
      end
      ST_DR_CHK: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = mglg_pkg::SRC_PEND;
          if (st_i.drain_ok) begin
            cmd_o.drain_grant = 1'b1;
            state_d           = ST_DR_RD;
          end else begin
            cmd_o.out_last = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/mglg_datapath.sv
// ----------------------------------------------------------------------------
// mglg_datapath
// holder table, wait queue, group mode and result registers
// ----------------------------------------------------------------------------
module mglg_datapath #(
  parameter int ID_BITS    = 4,
  parameter int HOLD_DEPTH = 16,
  parameter int WAIT_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mglg_pkg::cmd_t     cmd_i,
  output mglg_pkg::st_t      st_o,
  input  logic               func_i,
  input  logic [ID_BITS-1:0] requester_i,
  input  logic [2:0]         lock_mode_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic [ID_BITS-1:0] agent_o,
  output logic [2:0]         granted_mode_o,
  output logic               last_o
);

  localparam int HA  = $clog2(HOLD_DEPTH);
  localparam int HCW = $clog2(HOLD_DEPTH + 1);
  localparam int WA  = $clog2(WAIT_DEPTH);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int WS  = WCW + 1;
  localparam logic [HCW-1:0] HOLD_MAX  = HCW'(HOLD_DEPTH);
  localparam logic [WCW-1:0] WAIT_MAX  = WCW'(WAIT_DEPTH);
  localparam logic [WA-1:0]  HEAD_LAST = WA'(WAIT_DEPTH - 1);

  // item registers
  logic               func_q;
  logic [ID_BITS-1:0] id_q;
  logic [2:0]         mode_q;

  // lock state
  logic [HCW-1:0] hc_q, hc_d;
  logic [HCW-1:0] idx_q, idx_d;
  logic [2:0]     group_q, group_d;
  logic [WA-1:0]  head_q, head_d;
  logic [WCW-1:0] cnt_q, cnt_d;
  logic [2:0]     fmode_q;

  // pending result (its last flag is decided later)
  logic [2:0]         pend_kind_q;
  logic [ID_BITS-1:0] pend_agent_q;
  logic [2:0]         pend_mode_q;

  // memories
  logic [ID_BITS-1:0] hold_id_mem [HOLD_DEPTH];
  logic [2:0]         hold_md_mem [HOLD_DEPTH];
  logic [ID_BITS-1:0] wait_id_mem [WAIT_DEPTH];
  logic [2:0]         wait_md_mem [WAIT_DEPTH];
  logic [ID_BITS-1:0] hrd_id_q, wrd_id_q;
  logic [2:0]         hrd_md_q, wrd_md_q;

  // output register
  logic               out_valid_q;
  logic [2:0]         out_kind_q;
  logic [ID_BITS-1:0] out_agent_q;
  logic [2:0]         out_mode_q;
  logic               out_last_q;

  logic               req_grant, hold_full, wait_full, req_now_ok, req_q_ok;
  logic [2:0]         req_kind;
  logic [WS-1:0]      tail_sum;
  logic [WA-1:0]      tail;
  logic [HCW-1:0]     idx_p1;
  logic               hw_en;
  logic [HA-1:0]      hw_addr, hr_addr;
  logic [ID_BITS-1:0] hw_id;
  logic [2:0]         hw_md;
  logic               out_free;

  assign hold_full  = (hc_q == HOLD_MAX);
  assign wait_full  = (cnt_q == WAIT_MAX);
  assign req_grant  = (cnt_q == '0) && mglg_pkg::compat(group_q, mode_q);
  assign req_now_ok = req_grant && !hold_full;
  assign req_q_ok   = !req_grant && !wait_full;

  always_comb begin
    if (req_grant) begin
      req_kind = hold_full ? mglg_pkg::KIND_FULL : mglg_pkg::KIND_NOW;
    end else begin
      req_kind = wait_full ? mglg_pkg::KIND_FULL : mglg_pkg::KIND_QUEUED;
    end
  end

  // circular tail, sum stays below twice the depth
  assign tail_sum = WS'(head_q) + WS'(cnt_q);
  always_comb begin
    if (tail_sum >= WS'(WAIT_DEPTH)) begin
      tail = WA'(tail_sum - WS'(WAIT_DEPTH));
    end else begin
      tail = WA'(tail_sum);
    end
  end

  assign idx_p1 = idx_q + HCW'(1);
  assign hr_addr = cmd_i.hold_rd_next ? idx_p1[HA-1:0] : idx_q[HA-1:0];

  assign hw_en = (cmd_i.req_do && req_now_ok) || cmd_i.drain_grant || cmd_i.hold_copy;
  always_comb begin
    if (cmd_i.hold_copy) begin
      hw_addr = idx_q[HA-1:0];
      hw_id   = hrd_id_q;
      hw_md   = hrd_md_q;
    end else if (cmd_i.drain_grant) begin
      hw_addr = hc_q[HA-1:0];
      hw_id   = wrd_id_q;
      hw_md   = wrd_md_q;
    end else begin
      hw_addr = hc_q[HA-1:0];
      hw_id   = id_q;
      hw_md   = mode_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) begin
      hold_id_mem[hw_addr] <= hw_id;
      hold_md_mem[hw_addr] <= hw_md;
    end
    if (cmd_i.hold_rd || cmd_i.hold_rd_next) begin
      hrd_id_q <= hold_id_mem[hr_addr];
      hrd_md_q <= hold_md_mem[hr_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_do && req_q_ok) begin
      wait_id_mem[tail] <= id_q;
      wait_md_mem[tail] <= mode_q;
    end
    if (cmd_i.wait_rd) begin
      wrd_id_q <= wait_id_mem[head_q];
      wrd_md_q <= wait_md_mem[head_q];
    end
  end

  // state updates
  always_comb begin
    hc_d    = hc_q;
    idx_d   = idx_q;
    group_d = group_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_p1;
    end
    if (cmd_i.req_do && req_now_ok) begin
      hc_d = hc_q + HCW'(1);
      if (group_q == mglg_pkg::MODE_NONE) begin
        group_d = mode_q;
      end
    end
    if (cmd_i.req_do && req_q_ok) begin
      cnt_d = cnt_q + WCW'(1);
    end
    if (cmd_i.hc_dec) begin
      hc_d = hc_q - HCW'(1);
      if (hc_q == HCW'(1)) begin
        group_d = mglg_pkg::MODE_NONE;
      end
    end
    if (cmd_i.drain_grant) begin
      hc_d  = hc_q + HCW'(1);
      cnt_d = cnt_q - WCW'(1);
      head_d = (head_q == HEAD_LAST) ? '0 : head_q + WA'(1);
      if (hc_q == '0) begin
        group_d = wrd_md_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q    <= '0;
      idx_q   <= '0;
      group_q <= mglg_pkg::MODE_NONE;
      head_q  <= '0;
      cnt_q   <= '0;
    end else begin
      hc_q    <= hc_d;
      idx_q   <= idx_d;
      group_q <= group_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      id_q   <= requester_i;
      mode_q <= mglg_pkg::clip_mode(lock_mode_i);
    end
    if (cmd_i.found) begin
      fmode_q <= hrd_md_q;
    end
    if (cmd_i.pend_rel) begin
      pend_kind_q  <= mglg_pkg::KIND_RELEASED;
      pend_agent_q <= id_q;
      pend_mode_q  <= fmode_q;
    end else if (cmd_i.drain_grant) begin
      pend_kind_q  <= mglg_pkg::KIND_FROM_QUEUE;
      pend_agent_q <= wrd_id_q;
      pend_mode_q  <= wrd_md_q;
    end
  end

  // output stage
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_last_q <= cmd_i.out_last;
      case (cmd_i.out_src)
        mglg_pkg::SRC_REQ: begin
          out_kind_q  <= req_kind;
          out_agent_q <= id_q;
          out_mode_q  <= mode_q;
        end
        mglg_pkg::SRC_NOTHOLD: begin
          out_kind_q  <= mglg_pkg::KIND_NOT_HOLDER;
          out_agent_q <= id_q;
          out_mode_q  <= mglg_pkg::MODE_NONE;
        end
        mglg_pkg::SRC_REL: begin
          out_kind_q  <= mglg_pkg::KIND_RELEASED;
          out_agent_q <= id_q;
          out_mode_q  <= fmode_q;
        end
        default: begin
          out_kind_q  <= pend_kind_q;
          out_agent_q <= pend_agent_q;
          out_mode_q  <= pend_mode_q;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign agent_o        = out_agent_q;
  assign granted_mode_o = out_mode_q;
  assign last_o         = out_last_q;

  always_comb begin
    st_o            = '0;
    st_o.func       = func_q;
    st_o.hc_zero    = (hc_q == '0);
    st_o.idx_at_hc  = (idx_q == hc_q);
    st_o.idx_last   = (idx_p1 == hc_q);
    st_o.match      = (hrd_id_q == id_q);
    st_o.wait_empty = (cnt_q == '0);
    st_o.hold_full  = hold_full;
    st_o.drain_ok   = (hc_q == '0) || mglg_pkg::compat(group_q, wrd_md_q);
    st_o.out_free   = out_free;
  end

endmodule

>>> design/multi_granularity_lock_grant_core.sv
// ----------------------------------------------------------------------------
// multi_granularity_lock_grant_core
// lock manager for one object with the six multiple-granularity modes
// ----------------------------------------------------------------------------
// One item at a time: a lock request (func 0) or a release (func 1). A request
// is latched in ST_IDLE and decided in ST_REQ, which loads its result (granted
// now, queued in the FIFO wait queue, or full) into the output register once
// the output is free. The next item can then be taken in ST_IDLE. A release
// scans the holder table oldest first, one read and one compare per entry, and
// closes the gap behind the found entry, one read and one write per moved
// entry. It then gives the released (or not holder) result.
// When the last holder leaves, queued waiters are granted from the head, with
// one granted-from-queue result per waiter. The drain ends when the queue is
// empty or the holder table is full (checked in ST_DR_RD), or when an
// incompatible waiter stops it (checked in ST_DR_CHK after the read).
// last_o marks the final result of an item. The holder table and wait queue
// are single-port memories with registered reads. The input stalls while an
// item is in work. A held result at the output stalls the sequencer while it
// waits and is never lost. Modes 6 and 7 are taken as exclusive.
// ----------------------------------------------------------------------------
module multi_granularity_lock_grant_core #(
  parameter int ID_BITS    = 4,
  parameter int HOLD_DEPTH = 16,
  parameter int WAIT_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [ID_BITS-1:0] requester_i,
  input  logic [2:0]         lock_mode_i,
  // result out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic [ID_BITS-1:0] agent_o,
  output logic [2:0]         granted_mode_o,
  output logic               last_o
);

  mglg_pkg::cmd_t cmd;
  mglg_pkg::st_t  st;

  // sequencer: request, search, shift, release, drain
  mglg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // holder table, wait queue, group mode, result register
  mglg_datapath #(
    .ID_BITS    (ID_BITS),
    .HOLD_DEPTH (HOLD_DEPTH),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .func_i         (func_i),
    .requester_i    (requester_i),
    .lock_mode_i    (lock_mode_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .agent_o        (agent_o),
    .granted_mode_o (granted_mode_o),
    .last_o         (last_o)
  );

endmodule

>>> design/mglg_checker.sv
// ----------------------------------------------------------------------------
// mglg_checker
// port-level checks on the lock grant core, bound to the top level
// ----------------------------------------------------------------------------
`include "multi_granularity_lock_grant_core_macros.svh"

module mglg_checker #(
  parameter int ID_BITS = 4
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               func_i,
  input logic [ID_BITS-1:0] requester_i,
  input logic [2:0]         lock_mode_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         kind_o,
  input logic [ID_BITS-1:0] agent_o,
  input logic [2:0]         granted_mode_o,
  input logic               last_o
);

  logic               out_hold;
  logic               in_hold;
  logic               kind_ok;
  logic               nh_res;
  logic               nh_ok;
  logic               req_res;
  logic [ID_BITS+6:0] res_bus;
  logic [ID_BITS+3:0] in_bus;

  assign out_hold = out_valid_o && out_stall_i;
  assign in_hold  = in_valid_i && in_stall_o;
  assign res_bus  = {kind_o, agent_o, granted_mode_o, last_o};
  assign in_bus   = {func_i, requester_i, lock_mode_i};
  assign kind_ok  = kind_o inside {mglg_pkg::KIND_NOW, mglg_pkg::KIND_QUEUED,
                                   mglg_pkg::KIND_RELEASED, mglg_pkg::KIND_FROM_QUEUE,
                                   mglg_pkg::KIND_NOT_HOLDER, mglg_pkg::KIND_FULL};
  assign nh_res   = out_valid_o && (kind_o == mglg_pkg::KIND_NOT_HOLDER);
  assign nh_ok    = last_o && (granted_mode_o == mglg_pkg::MODE_NONE);
  assign req_res  = out_valid_o &&
                    ((kind_o == mglg_pkg::KIND_NOW) || (kind_o == mglg_pkg::KIND_QUEUED));

  `MGLG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold,
                    out_valid_o && $stable(res_bus), "stalled result changed")
  `MGLG_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_hold,
                    in_valid_i && $stable(in_bus), "stalled item changed")
  `MGLG_ASSERT_NOW(a_kind_range, clk_i, rst_ni, out_valid_o, kind_ok, "result kind out of range")
  `MGLG_ASSERT_NOW(a_not_holder, clk_i, rst_ni, nh_res, nh_ok, "bad not-holder result")
  `MGLG_ASSERT_NOW(a_req_last, clk_i, rst_ni, req_res, last_o, "request result not final")

endmodule

bind multi_granularity_lock_grant_core mglg_checker #(.ID_BITS(ID_BITS)) u_mglg_checker (.*);

>>> tb/sv/multi_granularity_lock_grant_core_tb.sv
// ----------------------------------------------------------------------------
// multi_granularity_lock_grant_core_tb
// self-checking bench for the multiple-granularity lock grant core
// ----------------------------------------------------------------------------
// A directed plan walks mode compatibility, undefined modes, queue drains,
// repeated holders, a full holder table, a full wait queue and releases by
// non-holders. Random requests and releases follow, most releases by
// current holders. Every result is checked against a predictor of the holder
// table and wait queue; a few plan rows carry a fixed expectation instead.
// ----------------------------------------------------------------------------
module multi_granularity_lock_grant_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_W   = 4;
  localparam int HOLD_N = 16;
  localparam int WAIT_N = 16;

  // random part, and how many items at its end run with no idling
  localparam int RANDOM_N = 200;
  localparam int CALM_N   = 40;
  // cycles without any accepted item before the run is called hung
  localparam int HANG_LIMIT = 2000;
  // cycles watched after the last result for stray output
  localparam int TAIL_CYCLES = 150;

  // short names for the package codes
  localparam logic       F_REQ     = mglg_pkg::FUNC_REQUEST;
  localparam logic       F_REL     = mglg_pkg::FUNC_RELEASE;
  localparam logic [2:0] M_NONE    = mglg_pkg::MODE_NONE;
  localparam logic [2:0] M_IS      = mglg_pkg::MODE_IS;
  localparam logic [2:0] M_IX      = mglg_pkg::MODE_IX;
  localparam logic [2:0] M_S       = mglg_pkg::MODE_S;
  localparam logic [2:0] M_SIX     = mglg_pkg::MODE_SIX;
  localparam logic [2:0] M_X       = mglg_pkg::MODE_X;
  localparam logic [2:0] K_NOW     = mglg_pkg::KIND_NOW;
  localparam logic [2:0] K_QUEUED  = mglg_pkg::KIND_QUEUED;
  localparam logic [2:0] K_REL     = mglg_pkg::KIND_RELEASED;
  localparam logic [2:0] K_FROMQ   = mglg_pkg::KIND_FROM_QUEUE;
  localparam logic [2:0] K_NOTHOLD = mglg_pkg::KIND_NOT_HOLDER;
  localparam logic [2:0] K_FULL    = mglg_pkg::KIND_FULL;

  // modes 6 and 7 are undefined and behave as exclusive
  localparam logic [2:0] MODE_UNDEF6 = 3'd6;
  localparam logic [2:0] MODE_UNDEF7 = 3'd7;

  // compatibility of held mode (row) with requested mode (bit, left is none)
  localparam bit [0:5] GRANT_OK [6] = '{
    6'b111111,
    6'b111110,
    6'b111000,
    6'b110100,
    6'b110000,
    6'b100000
  };

  typedef struct packed {
    logic [2:0]      kind;
    logic [ID_W-1:0] agent;
    logic [2:0]      mode;
    logic            last;
  } outcome_t;

  // one plan row: item repeated with requester counting up from who;
  // pinned rows give exactly one result and carry its kind and mode
  typedef struct packed {
    logic       func;
    logic [3:0] who;
    logic [2:0] mode;
    logic [4:0] times;
    logic       pinned;
    logic [2:0] want_kind;
    logic [2:0] want_mode;
  } plan_row_t;

  localparam int PLAN_N = 31;
  localparam plan_row_t PLAN [PLAN_N] = '{
    // release straight after reset, nobody holds
    '{F_REL, 4'd3,  M_NONE,      5'd1,  1'b1, K_NOTHOLD, M_NONE},
    // undefined mode on an idle object is granted as exclusive
    '{F_REQ, 4'd15, MODE_UNDEF7, 5'd1,  1'b1, K_NOW,     M_X},
    '{F_REQ, 4'd0,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REQ, 4'd1,  M_IS,        5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REQ, 4'd2,  MODE_UNDEF6, 5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REL, 4'd15, M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    // last holder leaves: IS drains, the exclusive behind it stays
    '{F_REL, 4'd0,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    // compatible but queue not empty, so it waits
    '{F_REQ, 4'd4,  M_IS,        5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REL, 4'd1,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REL, 4'd2,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REL, 4'd4,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REQ, 4'd5,  M_IX,        5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REQ, 4'd6,  M_IS,        5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REQ, 4'd7,  M_S,         5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REQ, 4'd8,  M_SIX,       5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REL, 4'd6,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    // S drains and sets the group, SIX behind it blocks
    '{F_REL, 4'd5,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REL, 4'd7,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REL, 4'd8,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    // one agent holding twice, release takes the oldest entry
    '{F_REQ, 4'd9,  M_S,         5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REQ, 4'd9,  M_IS,        5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REL, 4'd9,  M_X,         5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REL, 4'd9,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    // exclusive holder, sixteen IS waiters fill the queue
    '{F_REQ, 4'd12, M_X,         5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REQ, 4'd0,  M_IS,        5'd16, 1'b0, K_NOW,     M_NONE},
    '{F_REQ, 4'd13, M_S,         5'd1,  1'b1, K_FULL,    M_S},
    // one release drains the whole queue into a full holder table
    '{F_REL, 4'd12, M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REQ, 4'd14, M_IS,        5'd1,  1'b1, K_FULL,    M_IS},
    '{F_REL, 4'd3,  M_NONE,      5'd1,  1'b0, K_NOW,     M_NONE},
    '{F_REL, 4'd0,  M_IS,        5'd16, 1'b0, K_NOW,     M_NONE},
    // mode is ignored on release
    '{F_REL, 4'd15, MODE_UNDEF7, 5'd1,  1'b1, K_NOTHOLD, M_NONE}
  };

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic            func_i;
  logic [ID_W-1:0] requester_i;
  logic [2:0]      lock_mode_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [2:0]      kind_o;
  logic [ID_W-1:0] agent_o;
  logic [2:0]      granted_mode_o;
  logic            last_o;

  multi_granularity_lock_grant_core #(
    .ID_BITS   (ID_W),
    .HOLD_DEPTH(HOLD_N),
    .WAIT_DEPTH(WAIT_N)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .requester_i   (requester_i),
    .lock_mode_i   (lock_mode_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .agent_o       (agent_o),
    .granted_mode_o(granted_mode_o),
    .last_o        (last_o)
  );

  // predicted lock state: holders in grant order, circular wait queue
  logic [ID_W-1:0] holder_who  [HOLD_N];
  logic [2:0]      holder_mode [HOLD_N];
  int              holders;
  logic [ID_W-1:0] waiter_who  [WAIT_N];
  logic [2:0]      waiter_mode [WAIT_N];
  int              waiter_head;
  int              waiters;
  logic [2:0]      group_mode;

  outcome_t item_outcomes [$];   // results of the item just taken
  outcome_t lock_outcomes_q [$]; // results still owed by the block
  outcome_t owed;

  int  errors;
  int  items_in;
  int  results_seen;
  int  kind_tally [8];
  int  hang_cycles;
  bit  calm;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic note(input logic [2:0] kind, input logic [ID_W-1:0] who,
                      input logic [2:0] mode);
    outcome_t o;
    o.kind  = kind;
    o.agent = who;
    o.mode  = mode;
    o.last  = 1'b0;
    item_outcomes = {item_outcomes, o};
  endtask

  // next lock state and the results of one item
  task automatic grant_or_release(input logic f, input logic [ID_W-1:0] who,
                                  input logic [2:0] req_mode);
    logic [2:0]      m;
    logic [2:0]      wm;
    logic [ID_W-1:0] wi;
    int              slot;
    item_outcomes.delete();
    m = (req_mode > M_X) ? M_X : req_mode;
    if (f == F_REQ) begin
      if (waiters == 0 && GRANT_OK[group_mode][m]) begin
        if (holders >= HOLD_N) begin
          note(K_FULL, who, m);
        end else begin
          holder_who[holders]  = who;
          holder_mode[holders] = m;
          holders++;
          if (group_mode == M_NONE) group_mode = m;
          note(K_NOW, who, m);
        end
      end else if (waiters >= WAIT_N) begin
        note(K_FULL, who, m);
      end else begin
        slot = (waiter_head + waiters) % WAIT_N;
        waiter_who[slot]  = who;
        waiter_mode[slot] = m;
        waiters++;
        note(K_QUEUED, who, m);
      end
    end else begin
      slot = -1;
      for (int k = 0; k < holders; k++)
        if (slot < 0 && holder_who[k] == who) slot = k;
      if (slot < 0) begin
        note(K_NOTHOLD, who, M_NONE);
      end else begin
        m = holder_mode[slot];
        for (int k = slot; k + 1 < holders; k++) begin
          holder_who[k]  = holder_who[k + 1];
          holder_mode[k] = holder_mode[k + 1];
        end
        holders--;
        note(K_REL, who, m);
        if (holders == 0) begin
          // the first waiter sets the group, the rest follow while compatible
          group_mode = M_NONE;
          while (waiters > 0 && holders < HOLD_N) begin
            wm = waiter_mode[waiter_head];
            wi = waiter_who[waiter_head];
            if (holders == 0) group_mode = wm;
            else if (!GRANT_OK[group_mode][wm]) break;
            holder_who[holders]  = wi;
            holder_mode[holders] = wm;
            holders++;
            waiter_head = (waiter_head + 1) % WAIT_N;
            waiters--;
            note(K_FROMQ, wi, wm);
          end
        end
      end
    end
    item_outcomes[item_outcomes.size() - 1].last = 1'b1;
  endtask

  // drive one item from a falling edge, hold it until taken, log its results
  task automatic offer(input logic f, input logic [ID_W-1:0] who,
                       input logic [2:0] mode, input logic pinned,
                       input logic [2:0] want_kind, input logic [2:0] want_mode);
    outcome_t o;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    requester_i <= who;
    lock_mode_i <= mode;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    grant_or_release(f, who, mode);
    if (pinned) begin
      // fixed expectation replaces the prediction for this row
      o.kind  = want_kind;
      o.agent = who;
      o.mode  = want_mode;
      o.last  = 1'b1;
      lock_outcomes_q = {lock_outcomes_q, o};
    end else begin
      foreach (item_outcomes[k]) lock_outcomes_q = {lock_outcomes_q, item_outcomes[k]};
    end
    items_in++;
    @(negedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
             $realtime, results_seen, what, got, want);
  endtask

  // result checker, oldest expectation first
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (lock_outcomes_q.size() == 0) begin
        flag_mismatch("unexpected result, kind", int'(kind_o), 0);
      end else begin
        owed = lock_outcomes_q.pop_front();
        if (kind_o !== owed.kind)
          flag_mismatch("kind", int'(kind_o), int'(owed.kind));
        if (agent_o !== owed.agent)
          flag_mismatch("agent", int'(agent_o), int'(owed.agent));
        if (granted_mode_o !== owed.mode)
          flag_mismatch("granted_mode", int'(granted_mode_o), int'(owed.mode));
        if (last_o !== owed.last)
          flag_mismatch("last", int'(last_o), int'(owed.last));
        kind_tally[owed.kind]++;
      end
      results_seen++;
    end
  end

  // hang detection: no item taken on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
      hang_cycles <= 0;
    else
      hang_cycles <= hang_cycles + 1;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("[%0t] no progress for %0d cycles, %0d results still owed",
               $realtime, HANG_LIMIT, lock_outcomes_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure: short bursts, with stretches of none
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 29) == 0) begin
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic            f;
    logic [ID_W-1:0] who;
    logic [2:0]      mode;
    int              pick;
    in_valid_i  = 1'b0;
    func_i      = F_REQ;
    requester_i = '0;
    lock_mode_i = M_NONE;
    rst_ni      = 1'b0;
    errors      = 0;
    items_in    = 0;
    results_seen = 0;
    hang_cycles = 0;
    calm        = 1'b0;
    holders     = 0;
    waiters     = 0;
    waiter_head = 0;
    group_mode  = M_NONE;
    foreach (kind_tally[k]) kind_tally[k] = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed plan
    for (int r = 0; r < PLAN_N; r++) begin
      for (int k = 0; k < PLAN[r].times; k++) begin
        who = ID_W'(int'(PLAN[r].who) + k);
        offer(PLAN[r].func, who, PLAN[r].mode, PLAN[r].pinned,
              PLAN[r].want_kind, PLAN[r].want_mode);
      end
    end

    // random traffic: releases by real holders, stray releases, and requests with mostly valid modes
    for (int n = 0; n < RANDOM_N; n++) begin
      calm = (n >= RANDOM_N - CALM_N);
      pick = $urandom_range(0, 99);
      mode = 3'($urandom);
      if (holders > 0 && pick < 42) begin
        f   = F_REL;
        who = holder_who[$urandom_range(0, holders - 1)];
      end else if (pick < 50) begin
        f   = F_REL;
        who = ID_W'($urandom);
      end else begin
        f   = F_REQ;
        who = ID_W'($urandom);
        if ($urandom_range(0, 9) != 0) mode = 3'($urandom_range(0, 5));
      end
      offer(f, who, mode, 1'b0, K_NOW, M_NONE);
    end
    in_valid_i <= 1'b0;

    wait (lock_outcomes_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d items, %0d results: %0d granted now, %0d queued, %0d released",
             items_in, results_seen, kind_tally[K_NOW], kind_tally[K_QUEUED],
             kind_tally[K_REL]);
    $display("  %0d granted from queue, %0d not holder, %0d full, %0d mismatches",
             kind_tally[K_FROMQ], kind_tally[K_NOTHOLD],
             kind_tally[K_FULL], errors);
    if (errors == 0 && lock_outcomes_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> multi_granularity_lock_grant_core.f
+incdir+design
design/mglg_pkg.sv
design/mglg_ctrl.sv
design/mglg_datapath.sv
design/multi_granularity_lock_grant_core.sv
design/mglg_checker.sv
tb/sv/multi_granularity_lock_grant_core_tb.sv
